// ===== rtl/eom_pkg.sv =====
// shared types and constants for the extent offset mapper
package eom_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned OFFSET_W  = 32;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned BLK_W     = 16;
   localparam int unsigned BSIZE_W   = 17;
   localparam int unsigned FIRST_W   = 17;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(512);
   localparam logic [BSIZE_W-1:0] BSIZE_MAX   = BSIZE_W'(65536);

   // register index of the block size, extents follow in start / count pairs
   localparam int unsigned REG_BSIZE = 0;

   // divider iteration counts: full offset, or a sum that fits the block size width
   localparam int unsigned DIV_WIDE_ITER   = OFFSET_W;
   localparam int unsigned DIV_NARROW_ITER = BSIZE_W;

   typedef struct packed {
      logic [BLK_W-1:0] start_block;
      logic [BLK_W-1:0] block_count;
   } ext_type;

   typedef struct packed {
      logic                start;
      logic                narrow;
      logic [OFFSET_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [OFFSET_W-1:0] quotient;
      logic [BSIZE_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== rtl/extent_offset_mapper.sv =====
// extent offset mapper top level: walk sequencer around the shared divider
//
//  channel   ports                         transfer
//  request   start, busy, req_*            start high while busy low
//  result    rsp_strobe, rsp_*             rsp_strobe high, one cycle each
//  config    psel, penable, pwrite, ...    psel, penable, pwrite, pready high
//
// a zero length request is answered in the cycle after its transfer
// otherwise each extent visited passes the read, multiply and compare states
// each extent touched adds a take step and a 17-step divide for the block count
// an offset inside the first touched extent adds a 32-step divide
// all divides run on the one shared divider
// reset is synchronous and returns the sequencer to idle, registers to defaults
// results cannot be stalled, so nothing holds the sequencer but the divider
module extent_offset_mapper
   import eom_pkg::*;
#(
   parameter int unsigned NUM_EXTENTS = 3,
   localparam int unsigned ADDR_W = $clog2(2*NUM_EXTENTS + 1) + 2
)
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [OFFSET_W-1:0] req_file_offset,
   input  logic [LEN_W-1:0]    req_byte_length,
   // result channel
   output logic                rsp_strobe,
   output logic                rsp_segment_valid,
   output logic [FIRST_W-1:0]  rsp_first_block,
   output logic [BLK_W-1:0]    rsp_block_count,
   output logic [LEN_W-1:0]    rsp_offset_in_block,
   output logic [LEN_W-1:0]    rsp_segment_bytes,
   output logic                rsp_needs_rmw,
   output logic                rsp_is_last,
   output logic                rsp_success,
   // configuration port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam int unsigned EXT_W = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FETCH = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_CMP   = 7'b0001000,
      S_DIV1  = 7'b0010000,
      S_TAKE  = 7'b0100000,
      S_DIV2  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic               segment_valid;
      logic [FIRST_W-1:0] first_block;
      logic [BLK_W-1:0]   block_count;
      logic [LEN_W-1:0]   offset_in_block;
      logic [LEN_W-1:0]   segment_bytes;
      logic               needs_rmw;
      logic               is_last;
      logic               success;
   } rsp_type;

   state_type           state_ff, state_in;
   logic                op_ff, op_in;
   logic [OFFSET_W-1:0] cur_ff, cur_in;         // offset left to skip
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    done_ff, done_in;       // bytes mapped so far
   logic [EXT_W-1:0]    idx_ff, idx_in;
   logic [OFFSET_W-1:0] ebytes_ff, ebytes_in;   // extent size in bytes
   logic [OFFSET_W-1:0] room_ff, room_in;       // bytes from offset to extent end
   logic [BLK_W-1:0]    blkoff_ff, blkoff_in;
   logic [LEN_W-1:0]    boff_ff, boff_in;
   logic [LEN_W-1:0]    take_ff, take_in;
   logic                pend_ff, pend_in;       // segment held until next extent is seen
   logic                strobe_ff, strobe_in;
   rsp_type             rsp_ff, rsp_in;

   ext_type             ext_rd;
   logic [BSIZE_W-1:0]  bs_eff;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic [OFFSET_W:0]   ext_prod;
   logic [LEN_W-1:0]    need;
   logic [LEN_W-1:0]    take_val;
   logic [LEN_W:0]      take_sum;
   logic [LEN_W:0]      done_sum;
   logic                last_ext;
   logic                accept;

   eom_csr #(
      .NUM_EXTENTS (NUM_EXTENTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .rd_idx    (idx_ff),
      .ext_rd    (ext_rd),
      .bsize_eff (bs_eff)
   );

   eom_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .divisor (bs_eff),
      .div_rsp (div_rsp)
   );

   assign accept   = start & (state_ff == S_IDLE);
   // extent bytes never exceed 32 bits: 16-bit count times at most 64 KiB
   assign ext_prod = (OFFSET_W+1)'(ext_rd.block_count) * (OFFSET_W+1)'(bs_eff);
   assign need     = len_ff - done_ff;
   assign take_val = (room_ff < OFFSET_W'(need)) ? room_ff[LEN_W-1:0] : need;
   assign take_sum = {1'b0, take_ff} + {1'b0, boff_ff};
   assign done_sum = {1'b0, done_ff} + {1'b0, take_ff};
   assign last_ext = idx_ff == EXT_W'(NUM_EXTENTS - 1);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cur_in    = cur_ff;
      len_in    = len_ff;
      done_in   = done_ff;
      idx_in    = idx_ff;
      ebytes_in = ebytes_ff;
      room_in   = room_ff;
      blkoff_in = blkoff_ff;
      boff_in   = boff_ff;
      take_in   = take_ff;
      pend_in   = pend_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      div_req   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_operation;
               cur_in  = req_file_offset;
               len_in  = req_byte_length;
               done_in = '0;
               idx_in  = '0;
               pend_in = 1'b0;
               if (req_byte_length == '0) begin
                  // empty request maps trivially
                  strobe_in      = 1'b1;
                  rsp_in         = '0;
                  rsp_in.is_last = 1'b1;
                  rsp_in.success = 1'b1;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            // extent read is registered in the csr block
            state_in = S_MUL;
         end
         S_MUL: begin
            if (ext_rd.block_count == '0) begin
               // end of list: close with the held segment or an empty result
               strobe_in = 1'b1;
               if (!pend_ff) begin
                  rsp_in = '0;
               end
               rsp_in.is_last = 1'b1;
               rsp_in.success = 1'b0;
               pend_in        = 1'b0;
               state_in       = S_IDLE;
            end else begin
               if (pend_ff) begin
                  strobe_in = 1'b1;
                  pend_in   = 1'b0;
               end
               ebytes_in = ext_prod[OFFSET_W-1:0];
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            if (cur_ff >= ebytes_ff) begin
               // extent lies wholly before the offset
               cur_in = cur_ff - ebytes_ff;
               if (last_ext) begin
                  strobe_in      = 1'b1;
                  rsp_in         = '0;
                  rsp_in.is_last = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  idx_in   = idx_ff + EXT_W'(1);
                  state_in = S_FETCH;
               end
            end else begin
               room_in = ebytes_ff - cur_ff;
               if (cur_ff == '0) begin
                  blkoff_in = '0;
                  boff_in   = '0;
                  state_in  = S_TAKE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.narrow   = 1'b0;
                  div_req.dividend = cur_ff;
                  state_in         = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               // quotient below the block count, remainder below the block size
               blkoff_in = div_rsp.quotient[BLK_W-1:0];
               boff_in   = div_rsp.remainder[LEN_W-1:0];
               state_in  = S_TAKE;
            end
         end
         S_TAKE: begin
            take_in          = take_val;
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = OFFSET_W'({1'b0, take_val} + {1'b0, boff_ff});
            state_in         = S_DIV2;
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               rsp_in.segment_valid   = 1'b1;
               rsp_in.first_block     = {1'b0, ext_rd.start_block} + {1'b0, blkoff_ff};
               rsp_in.block_count     = div_rsp.quotient[BLK_W-1:0]
                                        + BLK_W'(div_rsp.remainder != '0);
               rsp_in.offset_in_block = boff_ff;
               rsp_in.segment_bytes   = take_ff;
               // remainder of take plus offset equals take's own when offset is zero
               rsp_in.needs_rmw       = op_ff & ((boff_ff != '0) |
                                                 (div_rsp.remainder != '0));
               rsp_in.is_last         = 1'b0;
               rsp_in.success         = 1'b0;
               done_in                = done_sum[LEN_W-1:0];
               cur_in                 = '0;
               if ((done_sum == {1'b0, len_ff}) || last_ext) begin
                  strobe_in      = 1'b1;
                  rsp_in.is_last = 1'b1;
                  rsp_in.success = done_sum == {1'b0, len_ff};
                  state_in       = S_IDLE;
               end else begin
                  // whether this is last depends on the next extent's count
                  pend_in  = 1'b1;
                  idx_in   = idx_ff + EXT_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cur_ff    <= cur_in;
      len_ff    <= len_in;
      done_ff   <= done_in;
      idx_ff    <= idx_in;
      ebytes_ff <= ebytes_in;
      room_ff   <= room_in;
      blkoff_ff <= blkoff_in;
      boff_ff   <= boff_in;
      take_ff   <= take_in;
      rsp_ff    <= rsp_in;
   end

   assign busy                = state_ff != S_IDLE;
   assign pready              = 1'b1;
   assign rsp_strobe          = strobe_ff;
   assign rsp_segment_valid   = rsp_ff.segment_valid;
   assign rsp_first_block     = rsp_ff.first_block;
   assign rsp_block_count     = rsp_ff.block_count;
   assign rsp_offset_in_block = rsp_ff.offset_in_block;
   assign rsp_segment_bytes   = rsp_ff.segment_bytes;
   assign rsp_needs_rmw       = rsp_ff.needs_rmw;
   assign rsp_is_last         = rsp_ff.is_last;
   assign rsp_success         = rsp_ff.success;

`ifndef SYNTHESIS
   // a result only follows a transfer or sequencer activity
   assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff != S_IDLE || accept))
      else $error("result strobe without a request in flight");

   // every request ends on a last result
   assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (strobe_ff && rsp_ff.is_last))
      else $error("sequencer went idle without a last result");

   // an empty result always closes the request
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && !rsp_ff.segment_valid) |-> rsp_ff.is_last)
      else $error("empty result not marked last");

   // a mapped segment covers at least one byte and one block
   assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && rsp_ff.segment_valid) |->
         (rsp_ff.segment_bytes != '0 && rsp_ff.block_count != '0))
      else $error("mapped segment is empty");

   // the divider is only started on the way into a state that waits on it
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> (state_ff == S_DIV1 || state_ff == S_DIV2))
      else $error("divider started outside a divide step");
`endif

endmodule

// ===== rtl/eom_div.sv =====
// shared restoring divider, one quotient bit per cycle
module eom_div
   import eom_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  div_req_type         div_req,
   input  logic [BSIZE_W-1:0]  divisor,
   output div_rsp_type         div_rsp
);

   localparam int unsigned CNT_W = $clog2(DIV_WIDE_ITER + 1);
   localparam int unsigned PAD_W = OFFSET_W - BSIZE_W;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [OFFSET_W-1:0] dvd_ff, dvd_in;
   logic [OFFSET_W-1:0] quo_ff, quo_in;
   logic [BSIZE_W-1:0]  rem_ff, rem_in;
   logic [BSIZE_W-1:0]  dsr_ff, dsr_in;

   logic [BSIZE_W:0]    shifted;
   logic [BSIZE_W:0]    diff;
   logic                fits;

   assign shifted = {rem_ff, dvd_ff[OFFSET_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.narrow ? CNT_W'(DIV_NARROW_ITER) : CNT_W'(DIV_WIDE_ITER);
         // narrow operands skip the leading zero steps
         dvd_in  = div_req.narrow ? {div_req.dividend[BSIZE_W-1:0], {PAD_W{1'b0}}}
                                  : div_req.dividend;
         quo_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[OFFSET_W-2:0], 1'b0};
         quo_in = {quo_ff[OFFSET_W-2:0], fits};
         rem_in = fits ? diff[BSIZE_W-1:0] : shifted[BSIZE_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/eom_csr.sv =====
// configuration registers: block size and extent table
module eom_csr
   import eom_pkg::*;
#(
   parameter int unsigned NUM_EXTENTS = 3
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [$clog2(2*NUM_EXTENTS+1)+1:0] paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   input  logic [((NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1)-1:0] rd_idx,
   output ext_type                   ext_rd,
   output logic [BSIZE_W-1:0]        bsize_eff
);

   localparam int unsigned IDX_W    = $clog2(2*NUM_EXTENTS + 1);
   localparam int unsigned ADDR_W   = IDX_W + 2;
   localparam int unsigned EXT_W    = (NUM_EXTENTS > 1) ? $clog2(NUM_EXTENTS) : 1;
   localparam int unsigned LAST_REG = 2*NUM_EXTENTS;

   logic [BSIZE_W-1:0] bsize_ff, bsize_in;
   logic [BLK_W-1:0]   start_ff [NUM_EXTENTS];
   logic [BLK_W-1:0]   start_in [NUM_EXTENTS];
   logic [BLK_W-1:0]   count_ff [NUM_EXTENTS];
   logic [BLK_W-1:0]   count_in [NUM_EXTENTS];
   logic [DATA_W-1:0]  prdata_ff, prdata_in;
   ext_type            ext_rd_ff, ext_rd_in;

   logic [IDX_W-1:0]   reg_idx;
   logic [IDX_W-1:0]   reg_m1;
   logic [EXT_W-1:0]   ext_sel;
   logic               wr_en;
   logic               rd_setup;
   logic               in_list;

   assign reg_idx  = paddr[ADDR_W-1:2];
   assign reg_m1   = reg_idx - IDX_W'(1);
   assign ext_sel  = reg_m1[EXT_W:1];
   assign in_list  = reg_idx <= IDX_W'(LAST_REG);
   assign wr_en    = psel & penable & pwrite;
   assign rd_setup = psel & ~penable;

   always_comb begin
      bsize_in  = bsize_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      prdata_in = prdata_ff;
      if (wr_en) begin
         priority if (reg_idx == IDX_W'(REG_BSIZE)) begin
            bsize_in = pwdata[BSIZE_W-1:0];
         end else if (in_list) begin
            if (reg_m1[0]) begin
               count_in[ext_sel] = pwdata[BLK_W-1:0];
            end else begin
               start_in[ext_sel] = pwdata[BLK_W-1:0];
            end
         end
      end
      // read data captured in the setup phase, shown in the access phase
      if (rd_setup) begin
         priority if (reg_idx == IDX_W'(REG_BSIZE)) begin
            prdata_in = DATA_W'(bsize_ff);
         end else if (in_list) begin
            prdata_in = reg_m1[0] ? DATA_W'(count_ff[ext_sel]) : DATA_W'(start_ff[ext_sel]);
         end else begin
            prdata_in = '0;
         end
      end
      ext_rd_in.start_block = start_ff[rd_idx];
      ext_rd_in.block_count = count_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsize_ff <= BSIZE_RESET;
         for (int i = 0; i < NUM_EXTENTS; i++) begin
            start_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         bsize_ff <= bsize_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prdata_ff <= prdata_in;
      ext_rd_ff <= ext_rd_in;
   end

   // zero acts as one byte, anything above 64 KiB as 64 KiB
   always_comb begin
      priority if (bsize_ff == '0) begin
         bsize_eff = BSIZE_W'(1);
      end else if (bsize_ff > BSIZE_MAX) begin
         bsize_eff = BSIZE_MAX;
      end else begin
         bsize_eff = bsize_ff;
      end
   end

   assign prdata = prdata_ff;
   assign ext_rd = ext_rd_ff;

endmodule
